// ===== design/tefl_pkg.sv =====
// Shared types and constants for the timed event map floor lookup block.
// No dependencies; imported by every module of the block.
`default_nettype none
package tefl_pkg;

   localparam int TICK_W    = 31;
   localparam int VAL_W     = 8;
   localparam int DEPTH_DEF = 64;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Command codes on the request channel
   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   // Status codes on the result channel
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   // One stored event
   typedef struct packed {
      logic [TICK_W-1:0]       tick;
      logic signed [VAL_W-1:0] value;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/tefl_mem.sv =====
// Event table storage: one write port, one read port with registered read data.
// Depends on tefl_pkg for the entry type.
`default_nettype none
module tefl_mem
   import tefl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write and read the array; read data shows in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/tefl_seq.sv =====
// Command sequencer: walks the event table one entry at a time, reading,
// updating and writing back entries. Depends on tefl_pkg.
`default_nettype none
module tefl_seq
   import tefl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request side
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_command,
   input  wire logic [TICK_W-1:0]        req_tick,
   input  wire logic [TICK_W-1:0]        req_length,
   input  wire logic signed [VAL_W-1:0]  req_event_value,
   // finished item toward the output register
   output logic                          done_valid,
   input  wire logic                     done_ready,
   output logic signed [VAL_W-1:0]       done_found_value,
   output logic [1:0]                    done_status,
   // table memory
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output entry_type                     wr_data,
   output logic                          rd_en,
   output logic [IDX_W-1:0]              rd_addr,
   input  wire entry_type                rd_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_START  = 6'b000010,
      S_CALC   = 6'b000100,
      S_WRITE  = 6'b001000,
      S_PUTNEW = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [TICK_W-1:0]        len_ff, len_in;
   logic signed [VAL_W-1:0]  val_ff, val_in;
   logic [TICK_W:0]          end_ff, end_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TICK_W-1:0]        last_tick_ff, last_tick_in;
   logic                     full_ff, full_in;
   logic                     gt_ff, gt_in;
   logic                     eq_ff, eq_in;
   entry_type                ent_ff, ent_in;
   logic                     keep_ff, keep_in;
   logic                     sat_ff, sat_in;
   logic                     undo_ff, undo_in;
   logic [TICK_W-1:0]        new_tick_ff, new_tick_in;
   logic signed [VAL_W-1:0]  found_ff, found_in;
   logic [1:0]               status_ff, status_in;

   logic [CNT_W-1:0]         cnt_m1;
   logic [CNT_W-1:0]         k_ext;
   logic [TICK_W:0]          sum;

   assign cnt_m1 = count_ff - CNT_W'(1);
   assign k_ext  = CNT_W'(k_ff);
   assign sum    = {1'b0, rd_data.tick} + {1'b0, len_ff};

   assign req_ready        = (state_ff == S_IDLE);
   assign done_valid       = (state_ff == S_FINISH);
   assign done_found_value = found_ff;
   assign done_status      = status_ff;

   // Next-state and table access logic
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tick_in      = tick_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      last_tick_in = last_tick_ff;
      full_in      = full_ff;
      gt_in        = gt_ff;
      eq_in        = eq_ff;
      ent_in       = ent_ff;
      keep_in      = keep_ff;
      sat_in       = sat_ff;
      undo_in      = undo_ff;
      new_tick_in  = new_tick_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = k_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               tick_in   = req_tick;
               len_in    = req_length;
               val_in    = req_event_value;
               end_in    = {1'b0, req_tick} + {1'b0, req_length};
               found_in  = '0;
               status_in = ST_OK;
               full_in   = (count_ff == CNT_W'(DEPTH));
               n_in      = '0;
               undo_in   = 1'b0;
               unique case (cmd_type'(req_command))
                  CMD_SET: begin
                     if (count_ff == '0) begin
                        // empty table: store directly at the bottom
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data.tick  = req_tick;
                        wr_data.value = req_event_value;
                        count_in      = CNT_W'(1);
                        state_in      = S_FINISH;
                     end else begin
                        k_in     = IDX_W'(cnt_m1);
                        state_in = S_START;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        k_in     = IDX_W'(cnt_m1);
                        state_in = S_START;
                     end
                  end
                  CMD_INSERT, CMD_REMOVE: begin
                     if (req_tick == '0 || count_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        k_in     = '0;
                        state_in = S_START;
                     end
                  end
               endcase
            end
         end

         S_START: begin
            rd_en    = 1'b1;
            state_in = S_CALC;
         end

         // Evaluate the entry just read
         S_CALC: begin
            ent_in      = rd_data;
            gt_in       = (rd_data.tick > tick_ff);
            eq_in       = (rd_data.tick == tick_ff);
            keep_in     = 1'b1;
            sat_in      = 1'b0;
            new_tick_in = rd_data.tick;
            if (cmd_ff == CMD_INSERT) begin
               if (rd_data.tick >= tick_ff) begin
                  if (sum[TICK_W]) begin
                     new_tick_in = TICK_MAX;
                     sat_in      = 1'b1;
                  end else begin
                     new_tick_in = sum[TICK_W-1:0];
                  end
               end
            end else if (cmd_ff == CMD_REMOVE) begin
               if (rd_data.tick >= tick_ff) begin
                  keep_in     = ({1'b0, rd_data.tick} >= end_ff);
                  new_tick_in = rd_data.tick - len_ff;
               end
            end
            state_in = S_WRITE;
         end

         S_WRITE: begin
            unique case (cmd_ff)
               // Walk down from the top, shifting larger ticks up by one
               CMD_SET: begin
                  if (undo_ff) begin
                     // move the shifted entries back down by one
                     wr_en   = 1'b1;
                     wr_addr = k_ff - IDX_W'(1);
                     wr_data = ent_ff;
                     if (k_ext == count_ff) begin
                        state_in = S_FINISH;
                     end else begin
                        k_in     = k_ff + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = k_ff + IDX_W'(1);
                        state_in = S_CALC;
                     end
                  end else if (eq_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = k_ff;
                     wr_data.tick  = ent_ff.tick;
                     wr_data.value = val_ff;
                     if (!full_ff && k_ext != cnt_m1) begin
                        // larger entries already moved up: walk them back
                        undo_in  = 1'b1;
                        k_in     = IDX_W'(k_ext + CNT_W'(2));
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(k_ext + CNT_W'(2));
                        state_in = S_CALC;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end else if (!gt_ff) begin
                     if (full_ff) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(k_ext + CNT_W'(1));
                        wr_data.tick  = tick_ff;
                        wr_data.value = val_ff;
                        count_in      = count_ff + CNT_W'(1);
                     end
                     state_in = S_FINISH;
                  end else begin
                     if (!full_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(k_ext + CNT_W'(1));
                        wr_data = ent_ff;
                     end
                     if (k_ff == '0) begin
                        if (full_ff) begin
                           status_in = ST_FULL;
                           state_in  = S_FINISH;
                        end else begin
                           state_in = S_PUTNEW;
                        end
                     end else begin
                        k_in     = k_ff - IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = k_ff - IDX_W'(1);
                        state_in = S_CALC;
                     end
                  end
               end
               // Walk down until the first tick at or before the key
               CMD_LOOKUP: begin
                  if (!gt_ff) begin
                     found_in = ent_ff.value;
                     state_in = S_FINISH;
                  end else if (k_ff == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     k_in     = k_ff - IDX_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = k_ff - IDX_W'(1);
                     state_in = S_CALC;
                  end
               end
               // Walk up, compacting kept entries toward the bottom
               CMD_INSERT, CMD_REMOVE: begin
                  if (keep_ff) begin
                     wr_en         = 1'b1;
                     wr_data.tick  = new_tick_ff;
                     wr_data.value = ent_ff.value;
                     if (n_ff != '0 && last_tick_ff == new_tick_ff) begin
                        // merge into the entry written last
                        wr_addr = IDX_W'(n_ff - CNT_W'(1));
                     end else begin
                        wr_addr = IDX_W'(n_ff);
                        n_in    = n_ff + CNT_W'(1);
                     end
                     last_tick_in = new_tick_ff;
                  end
                  if (sat_ff) begin
                     status_in = ST_SAT;
                  end
                  if (k_ext == cnt_m1) begin
                     count_in = n_in;
                     state_in = S_FINISH;
                  end else begin
                     k_in     = k_ff + IDX_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = k_ff + IDX_W'(1);
                     state_in = S_CALC;
                  end
               end
            endcase
         end

         // Place the new entry at the bottom after the shift
         S_PUTNEW: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.tick  = tick_ff;
            wr_data.value = val_ff;
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_FINISH;
         end

         S_FINISH: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tick_ff      <= tick_in;
      len_ff       <= len_in;
      val_ff       <= val_in;
      end_ff       <= end_in;
      k_ff         <= k_in;
      n_ff         <= n_in;
      last_tick_ff <= last_tick_in;
      full_ff      <= full_in;
      gt_ff        <= gt_in;
      eq_ff        <= eq_in;
      ent_ff       <= ent_in;
      keep_ff      <= keep_in;
      sat_ff       <= sat_in;
      undo_ff      <= undo_in;
      new_tick_ff  <= new_tick_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
   end

endmodule
`default_nettype wire

// ===== design/timed_event_map_floor_lookup.sv =====
// Top level of the timed event map floor lookup block.
// Depends on tefl_pkg, tefl_mem and tefl_seq.
//
//  channel | ports                                           | dir
//  --------+-------------------------------------------------+----
//  request | req_valid req_ready req_command req_tick        | in
//          | req_length req_event_value                      |
//  result  | rsp_valid rsp_ready rsp_found_value rsp_status  | out
//
// One item at a time. Set and lookup walk down from the top, reading and
// evaluating each entry visited; a set that lands below every entry adds a
// final write at the bottom, and a set that finds its tick with room left
// moves the larger entries, already moved up, back down. Insert and remove
// visit every entry; a zero start tick or an empty table skips the walk.
// The single read port sets the pace: one entry read, then evaluated and
// written back. Reset clears the entry count, not the entries; no clearing pass. A
// stalled result sits in the output register while the next item is taken;
// the sequencer holds its finished item until that register frees.
`default_nettype none
module timed_event_map_floor_lookup
   import tefl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_command,
   input  wire logic [TICK_W-1:0]        req_tick,
   input  wire logic [TICK_W-1:0]        req_length,
   input  wire logic signed [VAL_W-1:0]  req_event_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [VAL_W-1:0]       rsp_found_value,
   output logic [1:0]                    rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   entry_type               rd_data;
   logic                    done_valid;
   logic                    done_ready;
   logic signed [VAL_W-1:0] done_found_value;
   logic [1:0]              done_status;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_found_value_ff;
   logic [1:0]              rsp_status_ff;

   tefl_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tefl_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_tick         (req_tick),
      .req_length       (req_length),
      .req_event_value  (req_event_value),
      .done_valid       (done_valid),
      .done_ready       (done_ready),
      .done_found_value (done_found_value),
      .done_status      (done_status),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   // Take a finished item whenever the output register is empty or draining
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && done_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_found_value_ff <= done_found_value;
         rsp_status_ff      <= done_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   // An accepted item keeps the sequencer busy in the cycle after the accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken again right after an accept");

   // A handed-off item appears on the result channel next cycle
   a_handoff_shows: assert property (@(posedge clock) disable iff (reset)
      (done_valid && done_ready) |=> rsp_valid)
      else $error("finished item lost in the output register");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_value)))
      else $error("stalled result changed");

   // Status never carries an undefined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
         || rsp_status == ST_SAT))
      else $error("undefined status code");
`endif

endmodule
`default_nettype wire
